>>> rtl/spt_pkg.sv
package spt_pkg;

  // sizing
  localparam int PAGE_COUNT = 64;
  localparam int PAGE_W     = 6;
  localparam int PAGE_SLOTS = 2 ** PAGE_W;
  localparam int TIME_BITS  = 32;
  localparam int LIFE_W     = 32;
  localparam int CMP_W      = (TIME_BITS > LIFE_W) ? TIME_BITS : LIFE_W;
  localparam int BUDGET_W   = 7;

  localparam logic [LIFE_W-1:0] LIFETIME_RESET = LIFE_W'(1000);

  // command kinds
  typedef enum logic [1:0] {
    KIND_REQUEST = 2'd0,
    KIND_COMMIT  = 2'd1,
    KIND_SWEEP   = 2'd2,
    KIND_TICK    = 2'd3
  } kind_t;

  // result events
  typedef enum logic [1:0] {
    EV_ANSWER = 2'd0,
    EV_COMMIT = 2'd1,
    EV_FREE   = 2'd2,
    EV_NONE   = 2'd3
  } event_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [PAGE_W-1:0]   page_index;
    logic                tail_level;
    logic [BUDGET_W-1:0] page_budget;
  } spt_cmd_t;

  typedef struct packed {
    logic [1:0]        event_res;
    logic [PAGE_W-1:0] page_index_out;
    logic              needs_load;
    logic              last;
  } spt_res_t;

endpackage

>>> rtl/spt_ram.sv
module spt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/sparse_page_residency_tracker.sv
// Request and tick: result strobed in the cycle after the start transfer; busy stays low.
// Commit: busy walking pages, one per cycle, and flushing; final result in the cycle after.
// Sweep: busy walking pages, then tail and flush states; final result in the cycle after.
// Sweep stamp reads are pipelined. A commit or sweep holds off new commands until done.
// Results are strobed once and never stalled. Synchronous reset clears flags and time,
// sets lifetime to 1000; stamps read as zero through per-page valid bits, no clearing pass.
module sparse_page_residency_tracker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  spt_pkg::spt_cmd_t     cmd,
  output logic                  result_valid,
  output spt_pkg::spt_res_t     result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [31:0]           cfg_data
);
  import spt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COMMIT,
    S_SWEEP,
    S_SWEEP_TAIL,
    S_FLUSH
  } state_t;

  localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(PAGE_COUNT - 1);

  state_t                state;
  logic [LIFE_W-1:0]     lifetime;
  logic [TIME_BITS-1:0]  now;
  logic [PAGE_SLOTS-1:0] committed;
  logic [PAGE_SLOTS-1:0] pending;
  logic [PAGE_SLOTS-1:0] stamp_valid;
  logic [PAGE_W-1:0]     idx;
  logic [BUDGET_W-1:0]   count;
  logic [BUDGET_W-1:0]   budget;
  logic                  chk_valid;
  logic [PAGE_W-1:0]     chk_idx;
  logic                  hold_valid;
  spt_res_t              hold;

  logic                  accept;
  logic                  req_hit;
  logic                  stamp_we;
  logic [TIME_BITS-1:0]  ram_rdata;
  logic [TIME_BITS-1:0]  stamp;
  logic [TIME_BITS-1:0]  age;
  logic                  found_commit;
  logic                  found_free;
  logic                  found;
  spt_res_t              found_res;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // a request that names a real page
  assign req_hit  = (kind_t'(cmd.kind) == KIND_REQUEST) && !cmd.tail_level &&
                    (BUDGET_W'(cmd.page_index) < BUDGET_W'(PAGE_COUNT));
  assign stamp_we = accept && req_hit;

  spt_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (PAGE_SLOTS)
  ) u_stamp_ram (
    .clk   (clk),
    .we    (stamp_we),
    .waddr (cmd.page_index),
    .wdata (now),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  // age of the page under check, never-stamped pages have a stamp of zero
  assign stamp = stamp_valid[chk_idx] ? ram_rdata : '0;
  assign age   = now - stamp;

  // shared find logic for the two walks
  assign found_commit = (state == S_COMMIT) && pending[idx] && (count < budget);
  assign found_free   = chk_valid && committed[chk_idx] &&
                        (CMP_W'(age) >= CMP_W'(lifetime));
  assign found        = found_commit || found_free;

  always_comb begin
    found_res.event_res      = found_commit ? EV_COMMIT : EV_FREE;
    found_res.page_index_out = found_commit ? idx : chk_idx;
    found_res.needs_load     = 1'b0;
    found_res.last           = 1'b0;
  end

  // sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      lifetime     <= LIFETIME_RESET;
      now          <= '0;
      committed    <= '0;
      pending      <= '0;
      stamp_valid  <= '0;
      idx          <= '0;
      count        <= '0;
      chk_valid    <= 1'b0;
      hold_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;

      // configuration transfer
      if (cfg_valid && cfg_ready) begin
        lifetime <= cfg_data;
      end

      // one result held back so the final one can carry last
      if (found) begin
        if (hold_valid) begin
          result_valid <= 1'b1;
          result       <= hold;
        end
        hold       <= found_res;
        hold_valid <= 1'b1;
        if (found_commit) begin
          committed[idx] <= 1'b1;
          count          <= count + BUDGET_W'(1);
        end else begin
          committed[chk_idx] <= 1'b0;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            idx        <= '0;
            count      <= '0;
            chk_valid  <= 1'b0;
            hold_valid <= 1'b0;
            budget     <= (cmd.page_budget == '0) ? BUDGET_W'(1) : cmd.page_budget;
            unique case (kind_t'(cmd.kind))
              KIND_REQUEST: begin
                result_valid             <= 1'b1;
                result.event_res         <= EV_ANSWER;
                result.page_index_out    <= req_hit ? cmd.page_index : '0;
                result.needs_load        <= req_hit && !committed[cmd.page_index];
                result.last              <= 1'b1;
                if (req_hit) begin
                  stamp_valid[cmd.page_index] <= 1'b1;
                  if (!committed[cmd.page_index]) begin
                    pending[cmd.page_index] <= 1'b1;
                  end
                end
              end
              KIND_COMMIT: state <= S_COMMIT;
              KIND_SWEEP:  state <= S_SWEEP;
              KIND_TICK: begin
                now                   <= now + TIME_BITS'(1);
                result_valid          <= 1'b1;
                result.event_res      <= EV_NONE;
                result.page_index_out <= '0;
                result.needs_load     <= 1'b0;
                result.last           <= 1'b1;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_COMMIT: begin
          idx <= idx + PAGE_W'(1);
          if (idx == LAST_PAGE) begin
            pending <= '0;
            state   <= S_FLUSH;
          end
        end
        S_SWEEP: begin
          chk_valid <= 1'b1;
          chk_idx   <= idx;
          idx       <= idx + PAGE_W'(1);
          if (idx == LAST_PAGE) begin
            state <= S_SWEEP_TAIL;
          end
        end
        S_SWEEP_TAIL: begin
          chk_valid <= 1'b0;
          state     <= S_FLUSH;
        end
        S_FLUSH: begin
          result_valid <= 1'b1;
          if (hold_valid) begin
            result      <= hold;
            result.last <= 1'b1;
          end else begin
            result.event_res      <= EV_NONE;
            result.page_index_out <= '0;
            result.needs_load     <= 1'b0;
            result.last           <= 1'b1;
          end
          hold_valid <= 1'b0;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> bench/spt_checker.sv
`timescale 1ns / 1ps

module spt_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  spt_pkg::spt_cmd_t cmd,
  input  logic              result_valid,
  input  spt_pkg::spt_res_t result,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [31:0]       cfg_data,
  output int                failures,
  output int                outstanding,
  output int                results_seen,
  output int                pages_committed,
  output int                pages_freed,
  output int                widest_command
);
  import spt_pkg::*;

  localparam int REPORT_CAP = 20;

  // shadow residency state
  logic [PAGE_COUNT-1:0] resident;
  logic [PAGE_COUNT-1:0] awaiting_commit;
  logic [TIME_BITS-1:0]  last_touch [PAGE_COUNT];
  logic [TIME_BITS-1:0]  tick_now;
  logic [LIFE_W-1:0]     lifetime;
  spt_res_t              owed_results [$];
  spt_res_t              oldest;
  int                    reports;

  // one field of a result; printing stops after a while, counting goes on
  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      failures++;
      if (reports < REPORT_CAP)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      reports++;
    end
  endtask

  // results owed for one accepted command, shadow state updated along the way
  task automatic apply_command(input spt_cmd_t c);
    spt_res_t             batch [$];
    spt_res_t             r;
    int                   budget;
    logic [TIME_BITS-1:0] age;
    r = '0;
    case (c.kind)
      KIND_REQUEST: begin
        r.event_res = EV_ANSWER;
        // tail mips have no page: answered without touching state
        if (!c.tail_level && int'(c.page_index) < PAGE_COUNT) begin
          r.page_index_out = c.page_index;
          last_touch[c.page_index] = tick_now;
          if (!resident[c.page_index]) begin
            awaiting_commit[c.page_index] = 1'b1;
            r.needs_load = 1'b1;
          end
        end
        batch.push_back(r);
      end
      KIND_COMMIT: begin
        // zero budget counts as one; above the page count it saturates by itself
        budget = (c.page_budget == '0) ? 1 : int'(c.page_budget);
        r.event_res = EV_COMMIT;
        for (int p = 0; p < PAGE_COUNT; p++) begin
          if (awaiting_commit[p] && batch.size() < budget) begin
            resident[p] = 1'b1;
            r.page_index_out = PAGE_W'(p);
            batch.push_back(r);
          end
          // leftovers beyond the budget are dropped
          awaiting_commit[p] = 1'b0;
        end
      end
      KIND_SWEEP: begin
        r.event_res = EV_FREE;
        for (int p = 0; p < PAGE_COUNT; p++) begin
          age = tick_now - last_touch[p];
          if (resident[p] && age >= lifetime) begin
            resident[p] = 1'b0;
            r.page_index_out = PAGE_W'(p);
            batch.push_back(r);
          end
        end
      end
      KIND_TICK: tick_now = tick_now + 1'b1;
      default: ;
    endcase
    // nothing done still answers once
    if (batch.size() == 0) begin
      r = '0;
      r.event_res = EV_NONE;
      batch.push_back(r);
    end
    r = batch.pop_back();
    r.last = 1'b1;
    batch.push_back(r);
    if (batch.size() > widest_command) widest_command = batch.size();
    foreach (batch[i]) owed_results.push_back(batch[i]);
  endtask

  // watch all three channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      resident = '0;
      awaiting_commit = '0;
      tick_now = '0;
      lifetime = LIFETIME_RESET;
      foreach (last_touch[i]) last_touch[i] = '0;
      owed_results.delete();
      failures = 0;
      reports = 0;
      results_seen = 0;
      pages_committed = 0;
      pages_freed = 0;
      widest_command = 0;
    end else begin
      // result transfer against the oldest expectation
      if (result_valid !== 1'b0) begin
        results_seen++;
        if (owed_results.size() == 0) begin
          failures++;
          if (reports < REPORT_CAP)
            $display("%0t: unexpected result, event %0d page %0d load %0b last %0b",
                     $time, result.event_res, result.page_index_out,
                     result.needs_load, result.last);
          reports++;
        end else begin
          oldest = owed_results.pop_front();
          check_field("event_res", 8'(oldest.event_res), 8'(result.event_res));
          check_field("page_index_out", 8'(oldest.page_index_out),
                      8'(result.page_index_out));
          check_field("needs_load", 8'(oldest.needs_load), 8'(result.needs_load));
          check_field("last", 8'(oldest.last), 8'(result.last));
          if (oldest.event_res == EV_COMMIT) pages_committed++;
          if (oldest.event_res == EV_FREE) pages_freed++;
        end
      end
      // lifetime register write
      if (cfg_valid && cfg_ready) lifetime = cfg_data;
      // command transfer
      if (start && !busy) apply_command(cmd);
    end
    outstanding = owed_results.size();
  end

endmodule

>>> bench/sparse_page_residency_tracker_tb.sv
`timescale 1ns / 1ps

module sparse_page_residency_tracker_tb;
  import spt_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_ITEMS = 20;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  spt_cmd_t    cmd;
  logic        result_valid;
  spt_res_t    result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  int failures;
  int outstanding;
  int results_seen;
  int pages_committed;
  int pages_freed;
  int widest_command;
  int items_sent;
  int lifetimes_written;
  int run_left;
  int cycle_count = 0;

  sparse_page_residency_tracker i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  spt_checker i_check (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .cmd             (cmd),
    .result_valid    (result_valid),
    .result          (result),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .failures        (failures),
    .outstanding     (outstanding),
    .results_seen    (results_seen),
    .pages_committed (pages_committed),
    .pages_freed     (pages_freed),
    .widest_command  (widest_command)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // bursts of back-to-back commands with random gaps, noise on cmd while idle
  task automatic pace();
    int gap;
    if (run_left > 0) begin
      run_left--;
    end else begin
      start = 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 80) : $urandom_range(1, 4);
      repeat (gap) begin
        cmd = spt_cmd_t'(16'($urandom));
        @(negedge clk);
      end
      run_left = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 40)
                                             : $urandom_range(0, 6);
    end
  endtask

  // one command transfer, driven at the falling edge
  task automatic send(input kind_t k, input int page, input bit tail, input int budget);
    cmd.kind = k;
    cmd.page_index = PAGE_W'(page);
    cmd.tail_level = tail;
    cmd.page_budget = BUDGET_W'(budget);
    start = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    items_sent++;
    pace();
  endtask

  task automatic request(input int page, input bit tail);
    send(KIND_REQUEST, page, tail, $urandom_range(0, 127));
  endtask

  // commit, sweep or tick; the unused fields carry noise
  task automatic command(input kind_t k, input int budget);
    send(k, $urandom_range(0, 63), 1'($urandom_range(0, 1)), budget);
  endtask

  // hold off until every owed result has come and the block is idle
  task automatic quiesce();
    start = 1'b0;
    while (outstanding != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_lifetime(input logic [31:0] value);
    quiesce();
    cfg_data = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_data = $urandom;
    lifetimes_written++;
  endtask

  // stimulus
  initial begin
    int          k;
    int          budget;
    int          random_from;
    logic [31:0] lt;
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    run_left = 0;
    items_sent = 0;
    lifetimes_written = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty sweep and commit, then a tick
    command(KIND_SWEEP, 3);
    command(KIND_COMMIT, 5);
    command(KIND_TICK, 0);
    // extreme pages, a tail request, a repeated request
    request(0, 0);
    request(63, 0);
    request(37, 1);
    request(63, 0);
    // zero budget commits the lowest pending page, the rest is dropped
    command(KIND_COMMIT, 0);
    request(0, 0);
    request(63, 0);
    // budget past the page count
    command(KIND_COMMIT, 127);
    command(KIND_TICK, 0);
    command(KIND_SWEEP, 0);
    // zero lifetime frees every committed page
    set_lifetime(32'd0);
    command(KIND_SWEEP, 64);

    // every page at once: widest commit, then aged out after two ticks
    set_lifetime(32'd2);
    for (int p = 0; p < PAGE_COUNT; p++) request(p, 0);
    command(KIND_COMMIT, 64);
    command(KIND_TICK, 0);
    command(KIND_SWEEP, 0);
    command(KIND_TICK, 0);
    command(KIND_SWEEP, 0);

    // longest lifetime keeps everything
    set_lifetime(32'hFFFF_FFFF);
    request(5, 0);
    request(0, 1);
    command(KIND_COMMIT, 64);
    command(KIND_TICK, 1);
    command(KIND_SWEEP, 2);

    // random request, commit, tick and sweep episodes
    random_from = items_sent;
    while (items_sent < random_from + RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 5))
          0: lt = 32'd1;
          1: lt = 32'd2;
          2: lt = $urandom_range(1, 8);
          3: lt = 32'd0;
          4: lt = 32'hFFFF_FFFF;
          default: lt = $urandom;
        endcase
        set_lifetime(lt);
      end
      k = $urandom_range(1, 10);
      repeat (k) begin
        case ($urandom_range(0, 9))
          0: command(KIND_TICK, $urandom_range(0, 127));
          1: command(kind_t'($urandom_range(0, 3)), $urandom_range(0, 127));
          2: request($urandom_range(0, 63), 1'b1);
          default: request($urandom_range(0, 63), 1'b0);
        endcase
      end
      case ($urandom_range(0, 3))
        0: budget = $urandom_range(0, 127);
        1: budget = $urandom_range(64, 127);
        default: budget = $urandom_range(1, k);
      endcase
      command(KIND_COMMIT, budget);
      repeat ($urandom_range(0, 3)) command(KIND_TICK, $urandom_range(0, 127));
      if ($urandom_range(0, 1) == 1) command(KIND_SWEEP, $urandom_range(0, 127));
      if ($urandom_range(0, 4) == 0) quiesce();
    end

    // drain and settle
    quiesce();
    repeat (PAGE_COUNT + 8) @(negedge clk);
    $display("%0d commands driven, %0d results checked: %0d pages committed, %0d freed",
             items_sent, results_seen, pages_committed, pages_freed);
    $display("%0d lifetime writes, widest command gave %0d results",
             lifetimes_written, widest_command);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/spt_pkg.sv
rtl/spt_ram.sv
rtl/sparse_page_residency_tracker.sv
bench/spt_checker.sv
bench/sparse_page_residency_tracker_tb.sv
